[sv/bpts_pkg.sv]
// ----------------------------------------------------------------------------
// bpts_pkg
// Shared types, constants and helpers of the bitmap priority task scheduler.
// ----------------------------------------------------------------------------
package bpts_pkg;

  localparam int TASKS   = 32;
  localparam int IDX_W   = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int PRI_W   = 5;
  localparam int CMD_W   = 3;
  localparam int TICKS_W = 16;
  localparam int WORD_W  = 32;
  localparam int QDEPTH  = 2;
  localparam int SCAN_LAST = TASKS - 1;

  typedef logic [TASKS-1:0] map_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_DELAY   = 3'd2,
    CMD_SUSPEND = 3'd3,
    CMD_RESUME  = 3'd4,
    CMD_DELETE  = 3'd5,
    CMD_FREE    = 3'd6,
    CMD_STATUS  = 3'd7
  } cmd_e;

  // Operations after decode; a status, a disabled tick and an out-of-range priority become OP_NOP.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_CREATE,
    OP_DELAY,
    OP_SUSPEND,
    OP_RESUME,
    OP_DELETE,
    OP_FREE
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   idx;
    logic [TICKS_W-1:0] ticks;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [PRI_W-1:0]  highest_ready;
    logic              none_ready;
    logic              switch_request;
    logic [WORD_W-1:0] ready_mask;
    logic [WORD_W-1:0] delayed_mask;
    logic [WORD_W-1:0] suspended_mask;
    logic              freed_valid;
    logic [PRI_W-1:0]  freed_priority;
    logic [WORD_W-1:0] tick_count;
  } res_t;

  // Highest set bit, zero when empty.
  function automatic logic [PRI_W-1:0] top_bit(input map_t v);
    logic [PRI_W-1:0] r;
    r = '0;
    for (int i = 0; i < TASKS; i++) begin
      if (v[i]) begin
        r = PRI_W'(i);
      end
    end
    return r;
  endfunction

endpackage

[sv/bpts_if.sv]
// ----------------------------------------------------------------------------
// bpts channel interfaces
// Command, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpts_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [bpts_pkg::CMD_W-1:0]   command;
  logic [bpts_pkg::PRI_W-1:0]   task_priority;
  logic [bpts_pkg::TICKS_W-1:0] delay_ticks;

  modport source (output valid, command, task_priority, delay_ticks, input ready);
  modport sink   (input valid, command, task_priority, delay_ticks, output ready);
endinterface

interface bpts_res_if;
  logic                        valid;
  logic                        ready;
  logic [bpts_pkg::PRI_W-1:0]  highest_ready;
  logic                        none_ready;
  logic                        switch_request;
  logic [bpts_pkg::WORD_W-1:0] ready_mask;
  logic [bpts_pkg::WORD_W-1:0] delayed_mask;
  logic [bpts_pkg::WORD_W-1:0] suspended_mask;
  logic                        freed_valid;
  logic [bpts_pkg::PRI_W-1:0]  freed_priority;
  logic [bpts_pkg::WORD_W-1:0] tick_count;

  modport source (output valid, highest_ready, none_ready, switch_request, ready_mask,
                  delayed_mask, suspended_mask, freed_valid, freed_priority,
                  tick_count, input ready);
  modport sink   (input valid, highest_ready, none_ready, switch_request, ready_mask,
                  delayed_mask, suspended_mask, freed_valid, freed_priority,
                  tick_count, output ready);
endinterface

interface bpts_cfg_if;
  logic valid;
  logic ready;
  logic tick_enable;

  modport source (output valid, tick_enable, input ready);
  modport sink   (input valid, tick_enable, output ready);
endinterface

[sv/bpts_ram.sv]
// ----------------------------------------------------------------------------
// bpts_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bpts_fifo.sv]
// ----------------------------------------------------------------------------
// bpts_fifo
// Short job queue between the decode front and the execution back end.
// ----------------------------------------------------------------------------
module bpts_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  bpts_pkg::job_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output bpts_pkg::job_t pop_data_o
);

  localparam int PTR_W = (bpts_pkg::QDEPTH > 1) ? $clog2(bpts_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(bpts_pkg::QDEPTH + 1);

  bpts_pkg::job_t   slot_q [bpts_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(bpts_pkg::QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(bpts_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(bpts_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/bpts_front.sv]
// ----------------------------------------------------------------------------
// bpts_front
// Accepts commands, holds tick_enable and decodes each command into a job.
// ----------------------------------------------------------------------------
module bpts_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  bpts_cmd_if.sink       cmd_i,
  bpts_cfg_if.sink       cfg_i,
  output logic           job_valid_o,
  input  logic           job_ready_i,
  output bpts_pkg::job_t job_o
);

  logic tick_en_q, tick_en_d;
  logic in_range;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    tick_en_d = tick_en_q;
    if (cfg_i.valid) begin
      tick_en_d = cfg_i.tick_enable;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_en_q <= 1'b1;
    end else begin
      tick_en_q <= tick_en_d;
    end
  end

  assign in_range = (32'(cmd_i.task_priority) < 32'(bpts_pkg::TASKS));

  always_comb begin
    job_o.idx   = cmd_i.task_priority[bpts_pkg::IDX_W-1:0];
    job_o.ticks = cmd_i.delay_ticks;
    job_o.op    = bpts_pkg::OP_NOP;
    case (bpts_pkg::cmd_e'(cmd_i.command))
      bpts_pkg::CMD_TICK:    job_o.op = tick_en_q ? bpts_pkg::OP_TICK : bpts_pkg::OP_NOP;
      bpts_pkg::CMD_CREATE:  job_o.op = in_range ? bpts_pkg::OP_CREATE : bpts_pkg::OP_NOP;
      bpts_pkg::CMD_DELAY:   job_o.op = in_range ? bpts_pkg::OP_DELAY : bpts_pkg::OP_NOP;
      bpts_pkg::CMD_SUSPEND: job_o.op = in_range ? bpts_pkg::OP_SUSPEND : bpts_pkg::OP_NOP;
      bpts_pkg::CMD_RESUME:  job_o.op = in_range ? bpts_pkg::OP_RESUME : bpts_pkg::OP_NOP;
      bpts_pkg::CMD_DELETE:  job_o.op = in_range ? bpts_pkg::OP_DELETE : bpts_pkg::OP_NOP;
      bpts_pkg::CMD_FREE:    job_o.op = bpts_pkg::OP_FREE;
      default:               job_o.op = bpts_pkg::OP_NOP;
    endcase
  end

  assign job_valid_o = cmd_i.valid;
  assign cmd_i.ready = job_ready_i;

endmodule

[sv/bpts_back.sv]
// ----------------------------------------------------------------------------
// bpts_back
// Executes jobs on the task bitmaps; a tick scans the wake-time RAM.
// ----------------------------------------------------------------------------
module bpts_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  bpts_pkg::job_t job_i,
  bpts_res_if.source     res_o
);

  bpts_pkg::state_e state_q, state_d;
  bpts_pkg::job_t   cur_q, cur_d;
  bpts_pkg::map_t   ready_q, ready_d;
  bpts_pkg::map_t   delayed_q, delayed_d;
  bpts_pkg::map_t   susp_q, susp_d;
  bpts_pkg::map_t   dead_q, dead_d;
  bpts_pkg::map_t   pw_q, pw_d;
  bpts_pkg::map_t   bit_sel;
  bpts_pkg::map_t   free_sel;
  logic [bpts_pkg::WORD_W-1:0] cnt_q, cnt_d;
  logic [bpts_pkg::PRI_W-1:0]  old_top_q, old_top_d;
  logic                        old_none_q, old_none_d;
  logic                        freed_v_q, freed_v_d;
  logic [bpts_pkg::PRI_W-1:0]  freed_p_q, freed_p_d;
  logic [bpts_pkg::PRI_W-1:0]  dead_top;
  logic [bpts_pkg::PRI_W-1:0]  new_top;
  logic [bpts_pkg::IDX_W-1:0]  scan_q, scan_d;
  logic                        chk_vld_q, chk_vld_d;
  logic [bpts_pkg::IDX_W-1:0]  chk_idx_q, chk_idx_d;
  bpts_pkg::res_t              res_q, res_d;
  logic                        res_vld_q, res_vld_d;
  logic                        res_free;
  logic                        ram_we;
  logic [bpts_pkg::WORD_W-1:0] wake;
  logic [bpts_pkg::WORD_W-1:0] ram_rdata;

  assign res_free = !res_vld_q || res_o.ready;
  assign bit_sel  = bpts_pkg::map_t'(1) << cur_q.idx;
  assign dead_top = bpts_pkg::top_bit(dead_q);
  assign free_sel = bpts_pkg::map_t'(1) << dead_top[bpts_pkg::IDX_W-1:0];
  assign new_top  = bpts_pkg::top_bit(ready_q);
  assign wake     = cnt_q + bpts_pkg::WORD_W'(cur_q.ticks);

  bpts_ram #(
    .WIDTH (bpts_pkg::WORD_W),
    .DEPTH (bpts_pkg::TASKS)
  ) u_wake_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_q.idx),
    .wdata_i (wake),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpts_pkg::ST_IDLE: begin
        if (pop_valid_i) begin
          state_d = bpts_pkg::ST_EXEC;
        end
      end
      bpts_pkg::ST_EXEC: begin
        state_d = (cur_q.op == bpts_pkg::OP_TICK) ? bpts_pkg::ST_SCAN : bpts_pkg::ST_FIN;
      end
      bpts_pkg::ST_SCAN: begin
        if (scan_q == bpts_pkg::IDX_W'(bpts_pkg::SCAN_LAST)) begin
          state_d = bpts_pkg::ST_DRAIN;
        end
      end
      bpts_pkg::ST_DRAIN: state_d = bpts_pkg::ST_FIN;
      bpts_pkg::ST_FIN: begin
        if (res_free) begin
          state_d = bpts_pkg::ST_IDLE;
        end
      end
      default: state_d = bpts_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cur_d      = cur_q;
    ready_d    = ready_q;
    delayed_d  = delayed_q;
    susp_d     = susp_q;
    dead_d     = dead_q;
    pw_d       = pw_q;
    cnt_d      = cnt_q;
    old_top_d  = old_top_q;
    old_none_d = old_none_q;
    freed_v_d  = freed_v_q;
    freed_p_d  = freed_p_q;
    scan_d     = scan_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    res_d      = res_q;
    res_vld_d  = res_vld_q && !res_o.ready;
    ram_we     = 1'b0;
    pop_ready_o = 1'b0;

    case (state_q)
      bpts_pkg::ST_IDLE: begin
        pop_ready_o = 1'b1;
        scan_d      = '0;
        if (pop_valid_i) begin
          cur_d = job_i;
        end
      end
      bpts_pkg::ST_EXEC: begin
        old_top_d  = new_top;
        old_none_d = (ready_q == '0);
        freed_v_d  = 1'b0;
        freed_p_d  = '0;
        case (cur_q.op)
          bpts_pkg::OP_TICK: begin
            cnt_d = cnt_q + 1'b1;
            // wrap: everything not waiting for the wrap is due, flags clear
            if (cnt_q == '1) begin
              ready_d   = ready_q | (delayed_q & ~pw_q);
              delayed_d = delayed_q & pw_q;
              pw_d      = '0;
            end
          end
          bpts_pkg::OP_CREATE: ready_d = ready_q | bit_sel;
          bpts_pkg::OP_DELAY: begin
            ram_we    = 1'b1;
            pw_d      = (wake < cnt_q) ? (pw_q | bit_sel) : (pw_q & ~bit_sel);
            delayed_d = delayed_q | bit_sel;
            ready_d   = ready_q & ~bit_sel;
          end
          bpts_pkg::OP_SUSPEND: begin
            ready_d = ready_q & ~bit_sel;
            susp_d  = susp_q | bit_sel;
          end
          bpts_pkg::OP_RESUME: begin
            susp_d  = susp_q & ~bit_sel;
            ready_d = ready_q | bit_sel;
          end
          bpts_pkg::OP_DELETE: begin
            ready_d = ready_q & ~bit_sel;
            dead_d  = dead_q | bit_sel;
          end
          bpts_pkg::OP_FREE: begin
            if (dead_q != '0) begin
              freed_v_d = 1'b1;
              freed_p_d = dead_top;
              dead_d    = dead_q & ~free_sel;
              ready_d   = ready_q & ~free_sel;
            end
          end
          default: ;
        endcase
      end
      bpts_pkg::ST_SCAN: begin
        chk_vld_d = 1'b1;
        chk_idx_d = scan_q;
        scan_d    = scan_q + 1'b1;
      end
      bpts_pkg::ST_FIN: begin
        if (res_free) begin
          res_vld_d            = 1'b1;
          res_d.highest_ready  = new_top;
          res_d.none_ready     = (ready_q == '0);
          res_d.switch_request = ((ready_q == '0) != old_none_q) || (new_top != old_top_q);
          res_d.ready_mask     = bpts_pkg::WORD_W'(ready_q);
          res_d.delayed_mask   = bpts_pkg::WORD_W'(delayed_q);
          res_d.suspended_mask = bpts_pkg::WORD_W'(susp_q);
          res_d.freed_valid    = freed_v_q;
          res_d.freed_priority = freed_p_q;
          res_d.tick_count     = cnt_q;
        end
      end
      default: ;
    endcase

    // wake-time check, one entry per cycle behind the RAM read
    if (chk_vld_q && delayed_q[chk_idx_q] && !pw_q[chk_idx_q] && (cnt_q >= ram_rdata)) begin
      delayed_d[chk_idx_q] = 1'b0;
      ready_d[chk_idx_q]   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bpts_pkg::ST_IDLE;
      ready_q   <= '0;
      delayed_q <= '0;
      susp_q    <= '0;
      dead_q    <= '0;
      pw_q      <= '0;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ready_q   <= ready_d;
      delayed_q <= delayed_d;
      susp_q    <= susp_d;
      dead_q    <= dead_d;
      pw_q      <= pw_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    old_top_q  <= old_top_d;
    old_none_q <= old_none_d;
    freed_v_q  <= freed_v_d;
    freed_p_q  <= freed_p_d;
    scan_q     <= scan_d;
    chk_idx_q  <= chk_idx_d;
    res_q      <= res_d;
  end

  assign res_o.valid          = res_vld_q;
  assign res_o.highest_ready  = res_q.highest_ready;
  assign res_o.none_ready     = res_q.none_ready;
  assign res_o.switch_request = res_q.switch_request;
  assign res_o.ready_mask     = res_q.ready_mask;
  assign res_o.delayed_mask   = res_q.delayed_mask;
  assign res_o.suspended_mask = res_q.suspended_mask;
  assign res_o.freed_valid    = res_q.freed_valid;
  assign res_o.freed_priority = res_q.freed_priority;
  assign res_o.tick_count     = res_q.tick_count;

`ifndef SYNTHESIS
  // a past-wrap flag only exists for a task that is still delayed
  a_pw_delayed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pw_q & ~delayed_q) == '0)
    else $error("past-wrap flag set on a task that is not delayed");

  a_tick_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpts_pkg::ST_EXEC && cur_q.op == bpts_pkg::OP_TICK)
    |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("tick did not advance the counter by one");

  a_chk_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> $past(state_q) == bpts_pkg::ST_SCAN)
    else $error("wake check outside a scan");

  a_res_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_vld_q) |-> $past(state_q) == bpts_pkg::ST_FIN)
    else $error("result loaded outside finish state");

  a_pop_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid_i && pop_ready_o) |=> state_q == bpts_pkg::ST_EXEC)
    else $error("popped job not executed");
`endif

endmodule

[sv/bitmap_priority_task_scheduler.sv]
// ----------------------------------------------------------------------------
// bitmap_priority_task_scheduler
// Bitmap task scheduler with tick-driven delayed wake-up.
//
//   channel   dir  port   payload
//   command   in   cmd_i  command, task_priority, delay_ticks
//   result    out  res_o  highest_ready .. tick_count, one per command
//   config    in   cfg_i  tick_enable (always ready)
//
// A command takes the back end through pick-up, execute and result load; an
// enabled tick adds the scan of the wake-time RAM, one entry per cycle through
// its single read port, and a drain. A two-entry queue decouples command intake
// from execution, and the result register lets the next command run while a
// result waits. Reset is asynchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_priority_task_scheduler (
  input  logic       clk_i,
  input  logic       rst_ni,
  bpts_cmd_if.sink   cmd_i,
  bpts_cfg_if.sink   cfg_i,
  bpts_res_if.source res_o
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  bpts_pkg::job_t push_job, pop_job;

  bpts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .cfg_i       (cfg_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  bpts_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  bpts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .job_i       (pop_job),
    .res_o       (res_o)
  );

endmodule

[tb/sv/bitmap_priority_task_scheduler_tb.sv]
// ----------------------------------------------------------------------------
// bitmap_priority_task_scheduler_tb
// Self-checking bench for the bitmap task scheduler. A directed table walks
// every command, both ends of the fields and the wake, release and switch
// cases. Random commands follow, under changing tick_enable settings and
// idle patterns. Every result is checked field by field against an in-bench
// scheduler model, or against the typed-in row where the table gives one.
// ----------------------------------------------------------------------------
module bitmap_priority_task_scheduler_tb;

  localparam int TASKS   = bpts_pkg::TASKS;
  localparam int PRI_W   = bpts_pkg::PRI_W;
  localparam int TICKS_W = bpts_pkg::TICKS_W;
  localparam int WORD_W  = bpts_pkg::WORD_W;

  typedef bpts_pkg::map_t map_t;
  typedef bpts_pkg::res_t res_t;
  typedef bpts_pkg::cmd_e cmd_e;

  localparam int STALL_LEN      = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 2 * TASKS + 20;
  localparam int DIRECTED_ROWS  = 25;

  typedef struct {
    cmd_e               cmd;
    logic [PRI_W-1:0]   pri;
    logic [TICKS_W-1:0] ticks;
    bit                 typed;
    res_t               exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  bpts_cmd_if cmd_if ();
  bpts_res_if res_if ();
  bpts_cfg_if cfg_if ();

  bitmap_priority_task_scheduler i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // Scheduler model state, reset values
  map_t              ready_map   = '0;
  map_t              delayed_map = '0;
  map_t              susp_map    = '0;
  map_t              dead_map    = '0;
  map_t              wrap_map    = '0;
  logic [WORD_W-1:0] tick_now    = '0;
  logic [WORD_W-1:0] wake_at [TASKS];
  bit                tick_en     = 1'b1;

  res_t result_q [$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   send_idle = 24;
  int   recv_idle = 77;
  int   stall_req = 0;
  int   stall_seen = 0;
  int   stall_left = 0;
  bit   cur_typed = 1'b0;
  res_t cur_exp = '0;

  // Expected results typed in: a status and a free on the empty scheduler, a tick
  // from reset, and the first create at the top priority.
  row_t directed [DIRECTED_ROWS] = '{
    '{bpts_pkg::CMD_STATUS,  5'd0,  16'h0000, 1'b1,
      res_t'{5'd0, 1'b1, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 5'd0, 32'd0}},
    '{bpts_pkg::CMD_FREE,    5'd31, 16'hFFFF, 1'b1,
      res_t'{5'd0, 1'b1, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 5'd0, 32'd0}},
    '{bpts_pkg::CMD_TICK,    5'd0,  16'h0000, 1'b1,
      res_t'{5'd0, 1'b1, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0, 5'd0, 32'd1}},
    '{bpts_pkg::CMD_CREATE,  5'd31, 16'h0000, 1'b1,
      res_t'{5'd31, 1'b0, 1'b1, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 5'd0, 32'd1}},
    '{bpts_pkg::CMD_CREATE,  5'd0,  16'hFFFF, 1'b0, '0},
    '{bpts_pkg::CMD_DELAY,   5'd0,  16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_TICK,    5'd0,  16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_DELAY,   5'd31, 16'hFFFF, 1'b0, '0},
    '{bpts_pkg::CMD_SUSPEND, 5'd0,  16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_RESUME,  5'd0,  16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_SUSPEND, 5'd17, 16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_DELETE,  5'd31, 16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_DELETE,  5'd0,  16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_FREE,    5'd0,  16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_FREE,    5'd0,  16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_FREE,    5'd0,  16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_CREATE,  5'd5,  16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_DELAY,   5'd5,  16'h0002, 1'b0, '0},
    '{bpts_pkg::CMD_TICK,    5'd0,  16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_TICK,    5'd0,  16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_RESUME,  5'd17, 16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_STATUS,  5'd31, 16'hAAAA, 1'b0, '0},
    '{bpts_pkg::CMD_DELAY,   5'd12, 16'h5555, 1'b0, '0},
    '{bpts_pkg::CMD_CREATE,  5'd1,  16'h0000, 1'b0, '0},
    '{bpts_pkg::CMD_STATUS,  5'd0,  16'h0000, 1'b0, '0}
  };

  initial begin
    foreach (wake_at[i]) wake_at[i] = '0;
  end

  function automatic logic [PRI_W-1:0] highest_set(input map_t m);
    for (int i = TASKS - 1; i >= 0; i--) begin
      if (m[i]) return PRI_W'(i);
    end
    return '0;
  endfunction

  // Applies one command to the model state and returns the expected result.
  function automatic res_t schedule(input cmd_e cmd, input logic [PRI_W-1:0] pri,
                                    input logic [TICKS_W-1:0] dt);
    res_t              r;
    map_t              due;
    map_t              one;
    logic [WORD_W-1:0] wake;
    logic [PRI_W-1:0]  old_top;
    logic              old_none;
    logic [PRI_W-1:0]  gone;
    r        = '0;
    due      = '0;
    one      = (int'(pri) < TASKS) ? (map_t'(1) << pri) : '0;
    old_top  = highest_set(ready_map);
    old_none = (ready_map == '0);
    case (cmd)
      bpts_pkg::CMD_TICK: begin
        if (tick_en) begin
          tick_now = tick_now + 1'b1;
          if (tick_now == '0) begin
            due      = delayed_map & ~wrap_map;
            wrap_map = '0;
          end
          for (int i = 0; i < TASKS; i++) begin
            if (delayed_map[i] && !wrap_map[i] && tick_now >= wake_at[i]) due[i] = 1'b1;
          end
          delayed_map &= ~due;
          ready_map   |= due;
        end
      end
      bpts_pkg::CMD_FREE: begin
        if (dead_map != '0) begin
          gone             = highest_set(dead_map);
          r.freed_valid    = 1'b1;
          r.freed_priority = gone;
          dead_map[gone]   = 1'b0;
          ready_map[gone]  = 1'b0;
        end
      end
      bpts_pkg::CMD_CREATE: ready_map |= one;
      bpts_pkg::CMD_DELAY: begin
        if (one != '0) begin
          wake         = tick_now + WORD_W'(dt);
          wake_at[pri] = wake;
          if (wake < tick_now) wrap_map |= one;
          else wrap_map &= ~one;
          delayed_map |= one;
          ready_map   &= ~one;
        end
      end
      bpts_pkg::CMD_SUSPEND: begin
        ready_map &= ~one;
        susp_map  |= one;
      end
      bpts_pkg::CMD_RESUME: begin
        susp_map  &= ~one;
        ready_map |= one;
      end
      bpts_pkg::CMD_DELETE: begin
        ready_map &= ~one;
        dead_map  |= one;
      end
      default: ;
    endcase
    r.highest_ready  = highest_set(ready_map);
    r.none_ready     = (ready_map == '0);
    r.switch_request = (r.none_ready != old_none) || (r.highest_ready != old_top);
    r.ready_mask     = WORD_W'(ready_map);
    r.delayed_mask   = WORD_W'(delayed_map);
    r.suspended_mask = WORD_W'(susp_map);
    r.tick_count     = tick_now;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Result check, model update on each transfer, and the watchdog.
  always @(posedge clk) begin : scoreboard
    res_t want;
    res_t got;
    res_t pred;
    bit   moved;
    moved = 1'b0;
    if (res_if.valid && res_if.ready) begin
      moved = 1'b1;
      got = '{res_if.highest_ready, res_if.none_ready, res_if.switch_request,
              res_if.ready_mask, res_if.delayed_mask, res_if.suspended_mask,
              res_if.freed_valid, res_if.freed_priority, res_if.tick_count};
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual %h", $time, got);
      end else begin
        want = result_q.pop_front();
        check_field("highest_ready", WORD_W'(want.highest_ready), WORD_W'(got.highest_ready));
        check_field("none_ready", WORD_W'(want.none_ready), WORD_W'(got.none_ready));
        check_field("switch_request", WORD_W'(want.switch_request),
                    WORD_W'(got.switch_request));
        check_field("ready_mask", want.ready_mask, got.ready_mask);
        check_field("delayed_mask", want.delayed_mask, got.delayed_mask);
        check_field("suspended_mask", want.suspended_mask, got.suspended_mask);
        check_field("freed_valid", WORD_W'(want.freed_valid), WORD_W'(got.freed_valid));
        check_field("freed_priority", WORD_W'(want.freed_priority),
                    WORD_W'(got.freed_priority));
        check_field("tick_count", want.tick_count, got.tick_count);
      end
    end
    if (cmd_if.valid && cmd_if.ready) begin
      moved = 1'b1;
      pred = schedule(cmd_e'(cmd_if.command), cmd_if.task_priority, cmd_if.delay_ticks);
      result_q.push_back(cur_typed ? cur_exp : pred);
    end
    if (cfg_if.valid && cfg_if.ready) begin
      moved   = 1'b1;
      tick_en = cfg_if.tick_enable;
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random back-pressure plus one long hold-off on request.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      stall_left = STALL_LEN;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_item(input cmd_e cmd, input logic [PRI_W-1:0] pri,
                           input logic [TICKS_W-1:0] dt, input bit typed,
                           input res_t exp);
    while ($urandom_range(99) < send_idle) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.command       <= cmd;
    cmd_if.task_priority <= pri;
    cmd_if.delay_ticks   <= dt;
    cur_typed            <= typed;
    cur_exp              <= exp;
    do @(posedge clk); while (!cmd_if.ready);
    @(negedge clk);
  endtask

  // Mostly short delays so that tasks wake while the counter is small.
  task automatic send_random();
    cmd_e               cmd;
    logic [TICKS_W-1:0] dt;
    int                 pick;
    pick = $urandom_range(99);
    if (pick < 28) cmd = bpts_pkg::CMD_TICK;
    else if (pick < 43) cmd = bpts_pkg::CMD_CREATE;
    else if (pick < 58) cmd = bpts_pkg::CMD_DELAY;
    else if (pick < 66) cmd = bpts_pkg::CMD_SUSPEND;
    else if (pick < 74) cmd = bpts_pkg::CMD_RESUME;
    else if (pick < 82) cmd = bpts_pkg::CMD_DELETE;
    else if (pick < 94) cmd = bpts_pkg::CMD_FREE;
    else cmd = bpts_pkg::CMD_STATUS;
    if (cmd == bpts_pkg::CMD_DELAY && $urandom_range(9) != 0) begin
      dt = TICKS_W'($urandom_range(12));
    end else begin
      dt = TICKS_W'($urandom);
    end
    send_item(cmd, PRI_W'($urandom_range(31)), dt, 1'b0, '0);
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_tick_enable(input bit en);
    drain();
    cfg_if.valid       <= 1'b1;
    cfg_if.tick_enable <= en;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    cmd_if.valid         = 1'b0;
    cmd_if.command       = bpts_pkg::CMD_STATUS;
    cmd_if.task_priority = '0;
    cmd_if.delay_ticks   = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.tick_enable   = 1'b1;
    res_if.ready         = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      send_item(directed[i].cmd, directed[i].pri, directed[i].ticks,
                directed[i].typed, directed[i].exp);
    end
    write_tick_enable(1'b0);
    repeat (150) send_random();
    write_tick_enable(1'b1);
    repeat (400) send_random();

    drain();
    send_idle = 77;
    recv_idle = 24;
    write_tick_enable(1'b0);
    repeat (150) send_random();
    write_tick_enable(1'b1);
    repeat (450) send_random();

    // No idling; the long hold-off fills the block and blocks the command side
    drain();
    send_idle = 0;
    recv_idle = 0;
    write_tick_enable(1'b1);
    stall_req++;
    repeat (400) send_random();
    write_tick_enable(1'b0);
    repeat (100) send_random();
    write_tick_enable(1'b1);
    repeat (250) send_random();

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
